/* hdl/engine_rumble_force_curve_top_macros.svh */
// ----------------------------------------------------------------------------
// Engine rumble force curve: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ENGINE_RUMBLE_FORCE_CURVE_TOP_MACROS_SVH
`define ENGINE_RUMBLE_FORCE_CURVE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ERFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ERFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/erfc_pkg.sv */
// ----------------------------------------------------------------------------
// Engine rumble force curve package
// Widths, constants, reciprocals and the setup sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package erfc_pkg;

	localparam int NW = 30;   // numerator width
	localparam int RW = 30;   // reciprocal width, scale 2^30
	localparam int DW = 18;   // divisor width
	localparam int MW = 14;   // rpm width
	localparam int LANES = 3;

	localparam int LN_LIN = 0;
	localparam int LN_RUM = 1;
	localparam int LN_DRG = 2;

	localparam int FORCE_FULL_SCALE_DEF = 10000;
	localparam logic [MW-1:0] RPM_FLOOR = MW'(1200);
	localparam logic [MW-1:0] RPM_RESET = MW'(2500);

	localparam logic [RW-1:0] RECIP_275 = RW'(1073741824 / 275);
	localparam logic [RW-1:0] RECIP_325 = RW'(1073741824 / 325);
	localparam logic [RW-1:0] RECIP_2   = RW'(1073741824 / 2);

	localparam logic [NW-1:0] LIN_SAT    = NW'(20000);
	localparam logic [NW-1:0] RUMBLE_SAT = NW'(20000);
	localparam logic [NW:0]   DRAG_SAT   = (NW+1)'(40000);

	localparam logic [2:0] ADDR_MAX_RPM = 3'd0;

	typedef enum logic [1:0] {
		CS_LOAD,
		CS_CALC_M,
		CS_CALC_K,
		CS_RUN
	} cfg_state_t;

endpackage
`default_nettype wire

/* hdl/engine_rumble_force_curve_top.sv */
// ----------------------------------------------------------------------------
// Engine rumble force curve
// Maps one engine sample to linear, rumble and drag forces in a 5-stage pipe.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// config   | in        | psel/penable/pready| paddr, pwdata, prdata
// sample   | in        | in_valid/in_stall  | engine_rpm, throttle, engine_brake, base_force
// forces   | out       | out_valid/out_stall| linear_force, rumble_force, drag_force
//
// One request per cycle while in_stall is low; an accepted request passes through
// the v_s1 to v_s5 valid registers and shows on out_valid from v_s5.
// Divisions by max rpm use reciprocals from a bit-serial divider: after reset
// and after each max_engine_rpm write, in_stall stays high until both are ready.
// out_stall freezes the whole pipe; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "engine_rumble_force_curve_top_macros.svh"
module engine_rumble_force_curve_top #(
	parameter int FORCE_FULL_SCALE = erfc_pkg::FORCE_FULL_SCALE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [13:0] engine_rpm,
	input  wire logic [16:0] throttle,
	input  wire logic        engine_brake,
	input  wire logic [14:0] base_force,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [14:0] linear_force,
	output logic      [14:0] rumble_force,
	output logic      [15:0] drag_force
);
	import erfc_pkg::*;

	// config
	logic [MW-1:0] max_q, m_eff_q, mm650_q;
	logic [DW-1:0] den17_q;
	logic [19:0]   h40_q, k17m_q;
	logic [NW-1:0] n600k_q, n350k_q, m1000_q;
	logic [RW-1:0] rm_q, rk_q;
	logic [MW-1:0] m_eff;
	logic          cfg_wr;

	cfg_state_t state_q, state_nx;
	logic       busy;
	logic [4:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [30:0] quo_q;
	logic [DW-1:0] div_d;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW-1:0] rem_nx;
	logic [30:0]   quo_nx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_RPM);
	assign prdata = (paddr == ADDR_MAX_RPM) ? {18'd0, max_q} : 32'd0;
	assign m_eff  = (max_q < RPM_FLOOR) ? RPM_FLOOR : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= RPM_RESET;
		end else if (cfg_wr) begin
			max_q <= pwdata[MW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		m_eff_q <= m_eff;
		mm650_q <= m_eff - MW'(650);
		den17_q <= DW'(17) * (DW'(m_eff) - DW'(1000));
		h40_q   <= 20'(17) * (20'(m_eff) + 20'(1000));
		k17m_q  <= 20'(17) * 20'(m_eff);
		n600k_q <= NW'(600) * NW'(DW'(17) * (DW'(m_eff) - DW'(1000)));
		n350k_q <= NW'(350) * NW'(DW'(17) * (DW'(m_eff) - DW'(1000)));
		m1000_q <= NW'(1000) * NW'(m_eff);
	end

	// reciprocal divider: floor(2^30 / d), one bit per cycle
	assign div_d  = (state_q == CS_CALC_M) ? DW'(m_eff_q) : den17_q;
	assign rem_sh = {rem_q, (cnt_q == 5'd30)};
	assign ge     = rem_sh >= {1'b0, div_d};
	assign rem_nx = ge ? DW'(rem_sh - {1'b0, div_d}) : rem_sh[DW-1:0];
	assign quo_nx = {quo_q[29:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_LOAD;
			cnt_q   <= 5'd30;
			rem_q   <= '0;
			quo_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == CS_CALC_M || state_q == CS_CALC_K) begin
				if (cnt_q == 5'd0) begin
					cnt_q <= 5'd30;
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					cnt_q <= cnt_q - 5'd1;
					rem_q <= rem_nx;
					quo_q <= quo_nx;
				end
			end else begin
				cnt_q <= 5'd30;
				rem_q <= '0;
				quo_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_CALC_M && cnt_q == 5'd0) begin
			rm_q <= quo_nx[RW-1:0];
		end
		if (state_q == CS_CALC_K && cnt_q == 5'd0) begin
			rk_q <= quo_nx[RW-1:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CS_LOAD:   state_nx = CS_CALC_M;
			CS_CALC_M: if (cnt_q == 5'd0) state_nx = CS_CALC_K;
			CS_CALC_K: if (cnt_q == 5'd0) state_nx = CS_RUN;
			CS_RUN:    state_nx = CS_RUN;
			default:   state_nx = CS_LOAD;
		endcase
		if (cfg_wr) state_nx = CS_LOAD;
		busy = (state_q != CS_RUN);
	end

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	assign adv       = !(v_s5 && out_stall);
	assign in_stall  = !adv || busy;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && !in_stall;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: rumble segment, linear numerator, throttle product
	logic [NW-1:0] rn;
	logic [RW-1:0] rr;
	logic [DW-1:0] rd;
	logic [19:0]   r40, r20;
	logic [NW-1:0] rt;
	logic [NW-1:0] rpm_w;

	assign r40   = 20'(engine_rpm) * 20'd40;
	assign r20   = 20'(engine_rpm) * 20'd20;
	assign rpm_w = NW'(engine_rpm);

	always_comb begin
		rt = '0;
		if (engine_rpm < MW'(50)) begin
			rn = '0;
			rr = RECIP_2;
			rd = DW'(2);
		end else if (engine_rpm <= MW'(325)) begin
			rn = (rpm_w - NW'(50)) * NW'(4000);
			rr = RECIP_275;
			rd = DW'(275);
		end else if (engine_rpm <= MW'(650)) begin
			rn = NW'(1300000) - (rpm_w - NW'(325)) * NW'(3100);
			rr = RECIP_325;
			rd = DW'(325);
		end else if (engine_rpm <= MW'(850)) begin
			rn = NW'(1800) - (rpm_w - NW'(650)) * NW'(3);
			rr = RECIP_2;
			rd = DW'(2);
		end else if (r40 <= h40_q) begin
			rt = (rpm_w - NW'(850)) * NW'(10000);
			rn = (rt > n600k_q) ? '0 : n600k_q - rt;
			rr = rk_q;
			rd = den17_q;
		end else if (r20 <= k17m_q) begin
			rn = n350k_q + NW'(r40 - h40_q) * NW'(650);
			rr = rk_q;
			rd = den17_q;
		end else begin
			rn = m1000_q + NW'(r20 - k17m_q) * NW'(3000);
			rr = rm_q;
			rd = DW'(m_eff_q);
		end
	end

	logic [NW-1:0] nl_s1, nr_s1;
	logic [RW-1:0] rr_s1;
	logic [DW-1:0] rd_s1, dm_s1;
	logic [30:0]   prod_s1;
	logic [MW-1:0] rpm_s1;
	logic          brake_s1;
	logic [14:0]   base_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			nl_s1    <= rpm_w * NW'(FORCE_FULL_SCALE);
			nr_s1    <= rn;
			rr_s1    <= rr;
			rd_s1    <= rd;
			dm_s1    <= DW'(m_eff_q);
			prod_s1  <= 31'(throttle) * 31'(mm650_q);
			rpm_s1   <= engine_rpm;
			brake_s1 <= engine_brake;
			base_s1  <= base_force;
		end
	end

	// stage 2: drag numerator
	logic [31:0] e_raw, e_cap, rs, ad;
	logic [37:0] pm;
	logic        brake_mul;
	logic [NW-1:0] nd;

	assign e_raw = 32'(21299200) + 32'(prod_s1);
	assign e_cap = (e_raw > (32'(dm_s1) << 15)) ? (32'(dm_s1) << 15) : e_raw;
	assign rs    = 32'(rpm_s1) << 15;
	always_comb begin
		if (e_cap >= rs) begin
			ad        = e_cap - rs;
			brake_mul = 1'b1;
		end else begin
			ad        = rs - e_cap;
			brake_mul = brake_s1;
		end
		pm = 38'(ad) * (brake_mul ? 38'd250 : 38'd25);
		nd = (pm < 38'd163840000) ? '0 : NW'(pm >> 11);
	end

	logic [NW-1:0] n_s2 [LANES];
	logic [RW-1:0] r_s2 [LANES];
	logic [DW-1:0] d_s2 [LANES];
	logic [14:0]   base_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2[LN_LIN] <= nl_s1;
			r_s2[LN_LIN] <= rm_q;
			d_s2[LN_LIN] <= dm_s1;
			n_s2[LN_RUM] <= nr_s1;
			r_s2[LN_RUM] <= rr_s1;
			d_s2[LN_RUM] <= rd_s1;
			n_s2[LN_DRG] <= nd;
			r_s2[LN_DRG] <= rm_q;
			d_s2[LN_DRG] <= dm_s1;
			base_s2      <= base_s1;
		end
	end

	// stage 3: estimate quotient; stage 4: remainder; stage 5: fix and saturate
	logic [NW-1:0] n_s3 [LANES];
	logic [NW-1:0] q_s3 [LANES];
	logic [DW-1:0] d_s3 [LANES];
	logic [NW-1:0] q_s4 [LANES];
	logic [NW-1:0] rem_s4 [LANES];
	logic [DW-1:0] d_s4 [LANES];
	logic [14:0]   base_s3, base_s4;
	logic [NW-1:0] q_fix [LANES];
	logic [NW:0]   drag_sum;
	logic [14:0]   lin_s5, rum_s5;
	logic [15:0]   drg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				n_s3[i] <= n_s2[i];
				q_s3[i] <= NW'(((2*NW)'(n_s2[i]) * (2*NW)'(r_s2[i])) >> 30);
				d_s3[i] <= d_s2[i];
				q_s4[i] <= q_s3[i];
				rem_s4[i] <= n_s3[i] - NW'(q_s3[i] * NW'(d_s3[i]));
				d_s4[i] <= d_s3[i];
			end
			base_s3 <= base_s2;
			base_s4 <= base_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			q_fix[i] = (rem_s4[i] >= NW'(d_s4[i])) ? q_s4[i] + NW'(1) : q_s4[i];
		end
		drag_sum = (NW+1)'(base_s4) + (NW+1)'(q_fix[LN_DRG]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s5 <= (q_fix[LN_LIN] > LIN_SAT) ? LIN_SAT[14:0] : q_fix[LN_LIN][14:0];
			rum_s5 <= (q_fix[LN_RUM] > RUMBLE_SAT) ? RUMBLE_SAT[14:0] : q_fix[LN_RUM][14:0];
			drg_s5 <= (drag_sum > DRAG_SAT) ? DRAG_SAT[15:0] : drag_sum[15:0];
		end
	end

	assign linear_force = lin_s5;
	assign rumble_force = rum_s5;
	assign drag_force   = drg_s5;

	logic forces_in_range;
	assign forces_in_range = (linear_force <= 15'd20000) && (rumble_force <= 15'd20000)
		&& (drag_force <= 16'd40000);

	`ERFC_ASSERT_SAME(a_busy_stalls, busy, in_stall, "input taken during reciprocal setup")
	`ERFC_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v_s1, "accepted request lost")
	`ERFC_ASSERT_SAME(a_out_range, out_valid, forces_in_range, "force out of range")
	`ERFC_ASSERT_SAME(a_div_rem, state_q == CS_CALC_M || state_q == CS_CALC_K, rem_q < div_d, "divider remainder not below divisor")

endmodule
`default_nettype wire

/* bench/engine_rumble_force_curve_checker.sv */
// ----------------------------------------------------------------------------
// Engine rumble force curve checker
// Watches the register port and both channels, computes the expected forces
// for every accepted request and compares them, in order, with the outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module engine_rumble_force_curve_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [13:0] engine_rpm,
	input  logic [16:0] throttle,
	input  logic        engine_brake,
	input  logic [14:0] base_force,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [14:0] linear_force,
	input  logic [14:0] rumble_force,
	input  logic [15:0] drag_force,
	output int          fail_count,
	output int          pending
);
	import erfc_pkg::*;

	typedef struct packed {
		logic [14:0] lin;
		logic [14:0] rum;
		logic [15:0] drag;
	} force_set_t;

	force_set_t expected_forces[$];
	logic [13:0] rpm_limit;

	function automatic longint sat(longint v, longint hi);
		if (v < 0)
			return 0;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint rumble_curve(longint r, longint m);
		longint den, h40, n;
		den = 17 * (m - 1000);
		h40 = 17 * (1000 + m);
		if (r < 50)
			return 0;
		if (r <= 325)
			return ((r - 50) * 4000) / 275;
		if (r <= 650)
			return (4000 * 325 - (r - 325) * 3100) / 325;
		if (r <= 850)
			return (1800 - 3 * (r - 650)) / 2;
		if (40 * r <= h40) begin
			n = 600 * den - (r - 850) * 10000;
			return (n < 0) ? 0 : n / den;
		end
		if (20 * r <= 17 * m)
			return (350 * den + (40 * r - h40) * 650) / den;
		return (1000 * m + (20 * r - 17 * m) * 3000) / m;
	endfunction

	function automatic longint engine_drag(longint r, longint thr, logic brk, longint m);
		longint e, d;
		if (brk && thr == 0)
			e = 650 * 32768;
		else begin
			e = 650 * 32768 + thr * (m - 650);
			if (e > m * 32768)
				e = m * 32768;
		end
		d = e - r * 32768;
		if (d >= 0)
			d = d * 10;
		else if (brk)
			d = -d * 10;
		else
			d = -d;
		if (d < 20 * 64'sd327680)
			return 0;
		return (d * 4000) / (m * 327680);
	endfunction

	function automatic force_set_t forces_for(logic [13:0] r, logic [16:0] thr, logic brk,
			logic [14:0] base, logic [13:0] limit);
		force_set_t f;
		longint m;
		m = (limit < 1200) ? 1200 : longint'(limit);
		f.lin = 15'(sat((longint'(r) * FORCE_FULL_SCALE_DEF) / m, 20000));
		f.rum = 15'(sat(rumble_curve(r, m), 20000));
		f.drag = 16'(sat(longint'(base) + engine_drag(r, thr, brk, m), 40000));
		return f;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		force_set_t want;
		if (!arst_n) begin
			rpm_limit <= 14'(RPM_RESET);
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_MAX_RPM)
				rpm_limit <= pwdata[13:0];
			if (in_valid && !in_stall)
				expected_forces.push_back(forces_for(engine_rpm, throttle, engine_brake,
					base_force, rpm_limit));
			if (out_valid && !out_stall) begin
				if (expected_forces.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					fail_count++;
				end else begin
					want = expected_forces.pop_front();
					if (linear_force !== want.lin)
						report("linear_force", linear_force, want.lin);
					if (rumble_force !== want.rum)
						report("rumble_force", rumble_force, want.rum);
					if (drag_force !== want.drag)
						report("drag_force", drag_force, want.drag);
				end
			end
			pending = expected_forces.size();
		end
	end
endmodule

/* bench/tb_engine_rumble_force_curve_top.sv */
// ----------------------------------------------------------------------------
// Engine rumble force curve testbench
// Steps max rpm through several settings, drives directed breakpoint samples
// and random samples with random gaps and output stalls; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_engine_rumble_force_curve_top;
	import erfc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [13:0] engine_rpm;
	logic [16:0] throttle;
	logic        engine_brake;
	logic [14:0] base_force;
	logic        out_valid, out_stall;
	logic [14:0] linear_force, rumble_force;
	logic [15:0] drag_force;
	int          fail_count, pending;
	bit          steady;
	int          cur_limit;

	engine_rumble_force_curve_top dut (.*);

	engine_rumble_force_curve_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic send_sample(int r, int thr, bit brk, int base);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		engine_rpm = 14'(r);
		throttle = 17'(thr);
		engine_brake = brk;
		base_force = 15'(base);
		in_valid = 1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic random_sample();
		int r, thr, sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: r = $urandom_range(0, 16383);
			2: r = $urandom_range(0, 900);
			3: r = $urandom_range(800, (cur_limit < 1200 ? 1200 : cur_limit) + 50);
			default: r = $urandom_range(0, (cur_limit < 1200 ? 1200 : cur_limit) + 200);
		endcase
		sel = $urandom_range(0, 9);
		case (sel)
			0: thr = 0;
			1: thr = 65536;
			2: thr = $urandom_range(0, 131071);
			default: thr = $urandom_range(0, 65536);
		endcase
		send_sample(r, thr, $urandom_range(0, 1),
			($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 20000));
	endtask

	task automatic breakpoint_samples();
		int m, h, k;
		m = (cur_limit < 1200) ? 1200 : cur_limit;
		h = (17 * (1000 + m)) / 40;
		k = (17 * m) / 20;
		send_sample(0, 0, 1, 0);
		send_sample(49, 0, 0, 32767);
		send_sample(50, 65536, 0, 20000);
		send_sample(325, 131071, 1, 0);
		send_sample(326, 1, 0, 100);
		send_sample(650, 0, 1, 500);
		send_sample(651, 32768, 0, 500);
		send_sample(850, 65535, 1, 1000);
		send_sample(851, 0, 0, 1000);
		send_sample(h, 20000, 1, 3000);
		send_sample(h + 1, 20000, 0, 3000);
		send_sample(k, 40000, 0, 0);
		send_sample(k + 1, 40000, 1, 0);
		send_sample(m, 65536, 0, 7000);
		send_sample(m + 1, 65536, 1, 7000);
		send_sample(16383, 0, 1, 32767);
		send_sample(16383, 131071, 0, 16384);
		send_sample(2 * m, 0, 0, 20000);
		send_sample(670, 0, 1, 0);
		send_sample(660, 0, 0, 0);
	endtask

	task automatic wait_idle();
		in_valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	initial begin
		int limits[8];
		int reps;
		limits = '{2500, 1200, 16383, 0, 1000, 1201, 6000, 0};
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = ADDR_MAX_RPM;
		pwdata = 0;
		in_valid = 0;
		engine_rpm = 0;
		throttle = 0;
		engine_brake = 0;
		base_force = 0;
		steady = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				wait_idle();
				cur_limit = (p == 7) ? $urandom_range(1200, 16383) : limits[p];
				reg_write(ADDR_MAX_RPM, 32'(cur_limit));
			end else
				cur_limit = limits[0];
			steady = (p == 2);
			if (p < 3)
				breakpoint_samples();
			reps = 125;
			for (int i = 0; i < reps; i++) begin
				if (i % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				random_sample();
			end
		end
		in_valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		int wait_cycles;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			wait_cycles = steady ? 0 : $urandom_range(0, 11);
			@(negedge clk);
			if (wait_cycles > 0) begin
				out_stall = 1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall = 0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end
endmodule
